// ===== design/life_generation_engine_unit_macros.svh =====
// Assertion macros for the life generation engine.
// Included by the RTL files that carry concurrent assertions; needs a clk and rst_n in scope.
`ifndef LIFE_GENERATION_ENGINE_UNIT_MACROS_SVH
`define LIFE_GENERATION_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LGE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LGE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LGE_ASSERT(label, prop, msg)
`define LGE_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== design/lge_pkg.sv =====
// Shared constants of the life generation engine.
// No dependencies; used by life_generation_engine_unit.
`default_nettype none
package lge_pkg;
    localparam int DEF_GRID_WIDTH  = 128;
    localparam int DEF_GRID_HEIGHT = 64;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;
    // Unused opcode: does nothing and returns zero.
    localparam logic [1:0] OP_NOP   = 2'd3;
endpackage
`default_nettype wire

// ===== design/life_generation_engine_unit.sv =====
// Life generation engine: a toroidal Game of Life grid in a page-packed two-bank memory.
// Depends on lge_pkg and life_generation_engine_unit_macros.svh.
//
// Usage: commands arrive on the s_ stream (write byte, read byte, advance one generation),
// and every command returns exactly one byte on the m_ stream (the read byte, else zero).
// A write or an unused opcode finishes in the accepting state; a read also passes through
// ST_RDWAIT, as the grid memory has a registered read port. A step sweeps the grid one
// column at a time through three column shift registers and one shared eight-cell rule
// unit: each column is loaded page by page into the shift registers, and GRID_WIDTH+2
// columns are loaded in all; each new column is written back page by page. The pace is
// set by the single read port and the single write port of the memory.
// One command is in flight at a time; s_tready stays low while it works and while its
// result waits in the output register for the receiver, so a stalled receiver stalls input.
// After reset the block clears bank a, one byte a cycle, with s_tready low; bank b needs
// no clearing since a step overwrites it.
`default_nettype none
`include "life_generation_engine_unit_macros.svh"
module life_generation_engine_unit #(
    parameter int GRID_WIDTH  = lge_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = lge_pkg::DEF_GRID_HEIGHT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // opcode[1:0], byte_address[11:2], write_data[19:12]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata   // read_data[7:0]
);
    localparam int PAGES = (GRID_HEIGHT + 7) / 8;
    localparam int PB    = 8 * PAGES;
    localparam int GB    = GRID_WIDTH * PAGES;
    localparam int AW    = $clog2(2 * GB);
    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int FINAL_ROT = GRID_HEIGHT - 8 * (PAGES - 1);

    typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_RDWAIT, ST_LOAD, ST_WRITE} state_t;

    // Rotate the column toward row zero by amt rows, wrapping over GRID_HEIGHT rows.
    function automatic logic [PB-1:0] rot_col(input logic [PB-1:0] v, input int amt);
        logic [PB-1:0] res;
        res = '0;
        for (int i = 0; i < GRID_HEIGHT; i++)
        begin
            res[i] = v[(i + amt) % GRID_HEIGHT];
        end
        return res;
    endfunction

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic            bank_reg, bank_next;
    logic [XW-1:0]   x_reg, x_next;
    logic [XW-1:0]   ldcol_reg, ldcol_next;
    logic [PW-1:0]   pg_reg, pg_next;
    logic [PW-1:0]   rx_reg, rx_next;
    logic            iss_done_reg, iss_done_next;
    logic            rdpend_reg, rdpend_next;
    logic [1:0]      warm_reg, warm_next;
    logic [AW-1:0]   ldaddr_reg, ldaddr_next;
    logic [AW-1:0]   wraddr_reg, wraddr_next;
    logic [PB-1:0]   l_reg, l_next, c_reg, c_next, r_reg, r_next;
    logic            mvalid_reg, mvalid_next;
    logic [7:0]      mdata_reg, mdata_next;

    logic [7:0]      mem [2*GB];
    logic [7:0]      rdata_reg;
    logic            we;
    logic [AW-1:0]   wa, ra;
    logic [7:0]      wd;

    logic [1:0]      in_op;
    logic [9:0]      in_addr;
    logic [7:0]      in_data;
    logic            in_ok;
    logic [AW-1:0]   src_base, dst_base;
    logic [PB-1:0]   r_shift;
    logic [7:0]      new_byte;

    assign in_op    = s_tdata[1:0];
    assign in_addr  = s_tdata[11:2];
    assign in_data  = s_tdata[19:12];
    assign in_ok    = int'(in_addr) < GB;
    assign src_base = bank_reg ? AW'(GB) : '0;
    assign dst_base = bank_reg ? '0 : AW'(GB);
    assign r_shift  = {rdata_reg, r_reg[PB-1:8]};

    assign s_tready = (state_reg == ST_IDLE) && !mvalid_reg;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    // The rule unit: columns are rotated so that the current page sits in rows 0..7.
    always_comb
    begin
        logic [3:0] n;
        int up, dn;
        new_byte = '0;
        for (int k = 0; k < 8; k++)
        begin
            up = (k + GRID_HEIGHT - 1) % GRID_HEIGHT;
            dn = (k + 1) % GRID_HEIGHT;
            n = 4'(l_reg[up]) + 4'(l_reg[k]) + 4'(l_reg[dn]) + 4'(c_reg[up])
              + 4'(c_reg[dn]) + 4'(r_reg[up]) + 4'(r_reg[k]) + 4'(r_reg[dn]);
            if (int'(pg_reg) * 8 + k < GRID_HEIGHT)
            begin
                new_byte[k] = (n == 4'd3) || (c_reg[k] && n == 4'd2);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        bank_next     = bank_reg;
        x_next        = x_reg;
        ldcol_next    = ldcol_reg;
        pg_next       = pg_reg;
        rx_next       = rx_reg;
        iss_done_next = iss_done_reg;
        rdpend_next   = 1'b0;
        warm_next     = warm_reg;
        ldaddr_next   = ldaddr_reg;
        wraddr_next   = wraddr_reg;
        l_next        = l_reg;
        c_next        = c_reg;
        r_next        = r_reg;
        mvalid_next   = mvalid_reg && !m_tready;
        mdata_next    = mdata_reg;
        we            = 1'b0;
        wa            = clr_reg;
        wd            = '0;
        ra            = src_base + AW'(in_addr);

        unique case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(GB - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    mdata_next = '0;
                    case (in_op)
                        lge_pkg::OP_WRITE:
                        begin
                            we = in_ok;
                            wa = src_base + AW'(in_addr);
                            wd = in_data;
                            mvalid_next = 1'b1;
                        end
                        lge_pkg::OP_READ:
                        begin
                            if (in_ok)
                            begin
                                state_next = ST_RDWAIT;
                            end
                            else
                            begin
                                mvalid_next = 1'b1;
                            end
                        end
                        lge_pkg::OP_STEP:
                        begin
                            state_next    = ST_LOAD;
                            x_next        = '0;
                            ldcol_next    = XW'(GRID_WIDTH - 1);
                            ldaddr_next   = src_base + AW'(GRID_WIDTH - 1);
                            warm_next     = '0;
                            pg_next       = '0;
                            rx_next       = '0;
                            iss_done_next = 1'b0;
                        end
                        default:
                        begin
                            mvalid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_RDWAIT:
            begin
                mvalid_next = 1'b1;
                mdata_next  = rdata_reg;
                state_next  = ST_IDLE;
            end
            ST_LOAD:
            begin
                ra = ldaddr_reg;
                if (!iss_done_reg)
                begin
                    rdpend_next = 1'b1;
                    ldaddr_next = ldaddr_reg + AW'(GRID_WIDTH);
                    pg_next     = pg_reg + 1'b1;
                    if (pg_reg == PW'(PAGES - 1))
                    begin
                        iss_done_next = 1'b1;
                    end
                end
                if (rdpend_reg)
                begin
                    r_next  = r_shift;
                    rx_next = rx_reg + 1'b1;
                    if (rx_reg == PW'(PAGES - 1))
                    begin
                        ldcol_next = (ldcol_reg == XW'(GRID_WIDTH - 1)) ? '0 : ldcol_reg + 1'b1;
                        pg_next       = '0;
                        rx_next       = '0;
                        iss_done_next = 1'b0;
                        ldaddr_next   = src_base + AW'(ldcol_next);
                        if (warm_reg != 2'd2)
                        begin
                            warm_next = warm_reg + 1'b1;
                            l_next    = c_reg;
                            c_next    = r_shift;
                        end
                        else
                        begin
                            state_next  = ST_WRITE;
                            wraddr_next = dst_base + AW'(x_reg);
                        end
                    end
                end
            end
            ST_WRITE:
            begin
                we          = 1'b1;
                wa          = wraddr_reg;
                wd          = new_byte;
                wraddr_next = wraddr_reg + AW'(GRID_WIDTH);
                pg_next     = pg_reg + 1'b1;
                l_next      = rot_col(l_reg, 8);
                c_next      = rot_col(c_reg, 8);
                r_next      = rot_col(r_reg, 8);
                if (pg_reg == PW'(PAGES - 1))
                begin
                    // The last page's rotation also undoes the ragged-page offset, so the
                    // columns come back in natural row order.
                    l_next  = rot_col(c_reg, FINAL_ROT);
                    c_next  = rot_col(r_reg, FINAL_ROT);
                    pg_next = '0;
                    if (x_reg == XW'(GRID_WIDTH - 1))
                    begin
                        bank_next   = !bank_reg;
                        mvalid_next = 1'b1;
                        mdata_next  = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        x_next     = x_reg + 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rdata_reg <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            bank_reg     <= 1'b0;
            x_reg        <= '0;
            ldcol_reg    <= '0;
            pg_reg       <= '0;
            rx_reg       <= '0;
            iss_done_reg <= 1'b0;
            rdpend_reg   <= 1'b0;
            warm_reg     <= '0;
            ldaddr_reg   <= '0;
            wraddr_reg   <= '0;
            mvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            bank_reg     <= bank_next;
            x_reg        <= x_next;
            ldcol_reg    <= ldcol_next;
            pg_reg       <= pg_next;
            rx_reg       <= rx_next;
            iss_done_reg <= iss_done_next;
            rdpend_reg   <= rdpend_next;
            warm_reg     <= warm_next;
            ldaddr_reg   <= ldaddr_next;
            wraddr_reg   <= wraddr_next;
            mvalid_reg   <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg     <= l_next;
        c_reg     <= c_next;
        r_reg     <= r_next;
        mdata_reg <= mdata_next;
    end

    `LGE_ASSERT(a_no_accept_while_pending, (s_tvalid && s_tready) |-> !mvalid_reg, "accept with result pending")
    `LGE_ASSERT(a_write_after_warmup, (state_reg == ST_WRITE) |-> (warm_reg == 2'd2), "write before three columns loaded")
    `LGE_ASSERT(a_read_only_when_loading, rdpend_reg |-> (state_reg == ST_LOAD), "column data arrived outside load")
    `LGE_ASSERT(a_step_ends_with_result, ((state_reg == ST_WRITE) && (state_next == ST_IDLE)) |=> (mvalid_reg && mdata_reg == 8'd0), "step result missing")
endmodule
`default_nettype wire
